// ----- hdl/kmet_pkg.sv -----
`default_nettype none

package kmet_pkg;

    // Width of the scan code: row in the upper three bits, column in the lower three.
    localparam int unsigned CODE_W   = 6;
    localparam int unsigned HALF_W   = 3;
    localparam int unsigned SIZE_W   = 4;
    localparam int unsigned COL_BITS = 8;

    // Byte addresses of the configuration registers.
    localparam logic [2:0] ADDR_NUM_ROWS = 3'd0;
    localparam logic [2:0] ADDR_NUM_COLS = 3'd4;

    // Reset value of both size registers: the full matrix.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // One completed auto-scan.
    typedef struct packed {
        logic [COL_BITS-1:0] rows_col0;
        logic [COL_BITS-1:0] rows_col1;
        logic [COL_BITS-1:0] rows_col2;
        logic [COL_BITS-1:0] rows_col3;
        logic [COL_BITS-1:0] rows_col4;
        logic [COL_BITS-1:0] rows_col5;
        logic [COL_BITS-1:0] rows_col6;
        logic [COL_BITS-1:0] rows_col7;
        logic                raw_key_status;
    } t_in_item;

    // One key event or one empty scan-done item.
    typedef struct packed {
        logic              has_event;
        logic [CODE_W-1:0] scan_code;
        logic              key_down;
        logic              still_pressed;
        logic              last;
    } t_out_item;

    // Tracking state of one key.
    typedef struct packed {
        logic prs;  // pressed in this scan
        logic rep;  // press already reported
    } t_key_st;

    // Control shared by every cell of the ring.
    typedef struct packed {
        logic load;   // capture the pressed bits of a new scan
        logic shift;  // rotate the ring by one key
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- hdl/keypad_matrix_event_tracker_top.sv -----
`default_nettype none

// Channel    Direction  Handshake                    Payload
// in         request    i_in_valid / o_in_stall      i_in_data  (t_in_item)
// out        result     o_out_valid / i_out_stall    o_out_data (t_out_item)
// config     APB        psel, penable, pwrite, ...   num_rows at 0x0, num_cols at 0x4
//
// Each request is captured into the key cells; the ring of key cells then rotates once
// round past the head decoder, and the final result is released from the flush state.
// Reset is synchronous; it clears every key cell, the pressed flag and the sizes to 8.
// A stalled result holds the ring still; the next request is taken once the
// final result of the previous one has entered the output register.

module keypad_matrix_event_tracker_top
    import kmet_pkg::*;
#(
    parameter int unsigned MATRIX_DIM = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned NUM_KEYS = MATRIX_DIM * MATRIX_DIM;

    logic [SIZE_W-1:0]   r_num_rows;
    logic [SIZE_W-1:0]   r_num_cols;
    logic                busy;
    logic                start;
    logic [COL_BITS-1:0] col_mask [COL_BITS];
    logic [NUM_KEYS-1:0] hit;
    t_key_st             key_st [NUM_KEYS];
    t_key_st             head_next;
    t_cell_ctl           ctl;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= SIZE_RESET;
            r_num_cols <= SIZE_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                ADDR_NUM_ROWS: r_num_rows <= pwdata[SIZE_W-1:0];
                ADDR_NUM_COLS: r_num_cols <= pwdata[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_NUM_ROWS: prdata = {28'd0, r_num_rows};
            ADDR_NUM_COLS: prdata = {28'd0, r_num_cols};
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Requests are taken only while the sequencer is idle.
    assign o_in_stall = busy;
    assign start      = i_in_valid && !busy;

    assign col_mask[0] = i_in_data.rows_col0;
    assign col_mask[1] = i_in_data.rows_col1;
    assign col_mask[2] = i_in_data.rows_col2;
    assign col_mask[3] = i_in_data.rows_col3;
    assign col_mask[4] = i_in_data.rows_col4;
    assign col_mask[5] = i_in_data.rows_col5;
    assign col_mask[6] = i_in_data.rows_col6;
    assign col_mask[7] = i_in_data.rows_col7;

    // Ring of key cells in row-major order; cell 0 is the head.
    for (genvar i = 0; i < NUM_KEYS; i++) begin : g_cell
        localparam int unsigned ROW = i / MATRIX_DIM;
        localparam int unsigned COL = i % MATRIX_DIM;
        localparam logic [SIZE_W-1:0] ROW_L = SIZE_W'(ROW);
        localparam logic [SIZE_W-1:0] COL_L = SIZE_W'(COL);

        t_key_st shift_in;

        // A set bit counts only inside the configured size.
        assign hit[i] = col_mask[COL][ROW] && (ROW_L < r_num_rows) && (COL_L < r_num_cols);

        if (i == NUM_KEYS - 1) begin : g_tail
            assign shift_in = head_next;
        end else begin : g_mid
            assign shift_in = key_st[i+1];
        end

        kmet_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_load_prs (hit[i] && i_in_data.raw_key_status),
            .i_shift_in (shift_in),
            .o_state    (key_st[i])
        );
    end

    // Sequencer, head decoder and result register.
    kmet_sweep #(
        .MATRIX_DIM (MATRIX_DIM)
    ) u_sweep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_any_hit   (|hit),
        .i_raw       (i_in_data.raw_key_status),
        .i_num_rows  (r_num_rows),
        .i_num_cols  (r_num_cols),
        .i_head      (key_st[0]),
        .o_head_next (head_next),
        .o_ctl       (ctl),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- hdl/kmet_cell.sv -----
`default_nettype none

module kmet_cell
    import kmet_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_load_prs,
    input  wire t_key_st   i_shift_in,
    output t_key_st        o_state
);

    t_key_st r_state;
    t_key_st n_state;

    // A new scan only sets the pressed bit; the ring rotation moves the whole state on.
    always_comb begin
        n_state = r_state;
        if (i_ctl.load) begin
            n_state.prs = i_load_prs;
        end else if (i_ctl.shift) begin
            n_state = i_shift_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

// ----- hdl/kmet_sweep.sv -----
`default_nettype none

module kmet_sweep
    import kmet_pkg::*;
#(
    parameter int unsigned MATRIX_DIM = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_any_hit,
    input  wire logic              i_raw,
    input  wire logic [SIZE_W-1:0] i_num_rows,
    input  wire logic [SIZE_W-1:0] i_num_cols,
    input  wire t_key_st           i_head,
    output t_key_st                o_head_next,
    output t_cell_ctl              o_ctl,
    output logic                   o_busy,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_data
);

    localparam int unsigned POS_W = $clog2(MATRIX_DIM);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MATRIX_DIM - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [POS_W-1:0] r_row, n_row;
    logic [POS_W-1:0] r_col, n_col;
    logic             r_sticky, n_sticky;
    logic             r_pvalid, n_pvalid;
    logic [CODE_W-1:0] r_pcode, n_pcode;
    logic             r_pdown, n_pdown;
    logic             r_ovalid, n_ovalid;
    t_out_item        r_out, n_out;

    logic             slot_free;
    logic             in_range;
    logic             head_event;
    logic [CODE_W-1:0] head_code;

    // The output register can take a new result when empty or being drained.
    assign slot_free = !r_ovalid || !i_out_stall;

    // Decode the key at the head of the ring.
    assign in_range   = (SIZE_W'(r_row) < i_num_rows) && (SIZE_W'(r_col) < i_num_cols);
    assign head_event = in_range && (i_head.rep ^ i_head.prs);
    assign head_code  = {HALF_W'(r_row), HALF_W'(r_col)};

    // A key in range ends the scan reported exactly when it was pressed in it.
    always_comb begin
        o_head_next = i_head;
        if (in_range) begin
            o_head_next.rep = i_head.prs;
            o_head_next.prs = 1'b0;
        end
    end

    assign o_ctl.load  = i_start;
    assign o_ctl.shift = (r_state == ST_SWEEP) && slot_free;

    // Sequencer: rotate the ring once round, holding back one event so that
    // the final one can carry the last flag.
    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_col    = r_col;
        n_sticky = r_sticky;
        n_pvalid = r_pvalid;
        n_pcode  = r_pcode;
        n_pdown  = r_pdown;
        n_ovalid = r_ovalid && i_out_stall;
        n_out    = r_out;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SWEEP;
                    n_row   = '0;
                    n_col   = '0;
                    if (i_any_hit) begin
                        n_sticky = i_raw;
                    end
                end
            end
            ST_SWEEP: begin
                if (slot_free) begin
                    if (head_event) begin
                        if (r_pvalid) begin
                            n_ovalid = 1'b1;
                            n_out    = '{has_event: 1'b1, scan_code: r_pcode,
                                         key_down: r_pdown, still_pressed: r_sticky,
                                         last: 1'b0};
                        end
                        n_pvalid = 1'b1;
                        n_pcode  = head_code;
                        n_pdown  = i_head.prs;
                    end
                    if (r_col == POS_LAST) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                        if (r_row == POS_LAST) begin
                            n_state = ST_FLUSH;
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    if (r_pvalid) begin
                        n_out = '{has_event: 1'b1, scan_code: r_pcode, key_down: r_pdown,
                                  still_pressed: r_sticky, last: 1'b1};
                    end else begin
                        n_out = '{has_event: 1'b0, scan_code: '0, key_down: 1'b0,
                                  still_pressed: r_sticky, last: 1'b1};
                    end
                    n_pvalid = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_row    <= '0;
            r_col    <= '0;
            r_sticky <= 1'b0;
            r_pvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_sticky <= n_sticky;
            r_pvalid <= n_pvalid;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_pcode <= n_pcode;
        r_pdown <= n_pdown;
        r_out   <= n_out;
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import kmet_pkg::*;

    localparam int unsigned DIM          = 8;
    // Covers the capture, the rotation of the ring past every key and the release, plus margin.
    localparam int unsigned SWEEP_CYCLES = DIM * DIM + 4;
    localparam int unsigned CYCLE_LIMIT  = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_item    i_in_data = '0;
    logic        i_out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic [31:0] prdata;
    logic        pready;

    // Predicted state of the block.
    t_key_st           key_track [DIM*DIM];
    logic              still_down = 1'b0;
    logic [SIZE_W-1:0] cfg_rows = SIZE_RESET;
    logic [SIZE_W-1:0] cfg_cols = SIZE_RESET;

    // Key events still to come out of the block, oldest first.
    t_out_item   due_events [$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    logic        in_idling = 1'b1;
    logic        out_idling = 1'b1;
    int unsigned out_hold = 0;
    logic [63:0] held_keys = '0;

    keypad_matrix_event_tracker_top #(.MATRIX_DIM(DIM)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    // Give up if the run takes far longer than the slowest correct run would.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL keypad_matrix_event_tracker_top");
            $finish;
        end
    end

    // Result side stalls in random bursts while idling is enabled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_hold    <= 0;
        end else if (out_hold > 1) begin
            out_hold <= out_hold - 1;
        end else if (out_hold == 1) begin
            out_hold    <= 0;
            i_out_stall <= 1'b0;
        end else if (out_idling && $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            out_hold    <= $urandom_range(1, 18);
        end
    end

    // Every accepted result is compared with the oldest predicted event.
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_events.size() == 0) begin
                mismatches++;
                $error("result with nothing expected: %h", o_out_data);
            end else begin
                want = due_events.pop_front();
                if (o_out_data.has_event !== want.has_event) begin
                    mismatches++;
                    $error("has_event: expected %0d, got %0d",
                           want.has_event, o_out_data.has_event);
                end
                if (o_out_data.scan_code !== want.scan_code) begin
                    mismatches++;
                    $error("scan_code: expected %0d, got %0d",
                           want.scan_code, o_out_data.scan_code);
                end
                if (o_out_data.key_down !== want.key_down) begin
                    mismatches++;
                    $error("key_down: expected %0d, got %0d",
                           want.key_down, o_out_data.key_down);
                end
                if (o_out_data.still_pressed !== want.still_pressed) begin
                    mismatches++;
                    $error("still_pressed: expected %0d, got %0d",
                           want.still_pressed, o_out_data.still_pressed);
                end
                if (o_out_data.last !== want.last) begin
                    mismatches++;
                    $error("last: expected %0d, got %0d", want.last, o_out_data.last);
                end
            end
        end
    end

    function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v);
        return (v > DIM) ? DIM : int'(v);
    endfunction

    // Builds a scan from a key map indexed by row*8+col.
    function automatic t_in_item scan_from_map(logic [63:0] keymap, logic raw);
        logic [COL_BITS-1:0] cols [8];
        for (int c = 0; c < 8; c++) begin
            for (int r = 0; r < 8; r++) begin
                cols[c][r] = keymap[(r << HALF_W) + c];
            end
        end
        return t_in_item'({cols[0], cols[1], cols[2], cols[3],
                           cols[4], cols[5], cols[6], cols[7], raw});
    endfunction

    // Works out the events that one accepted scan produces and queues them.
    task automatic predict_scan(t_in_item scan);
        logic [COL_BITS-1:0] cols [8];
        int unsigned         nrows;
        int unsigned         ncols;
        int unsigned         idx;
        int unsigned         first;
        t_out_item           ev;
        cols  = '{scan.rows_col0, scan.rows_col1, scan.rows_col2, scan.rows_col3,
                  scan.rows_col4, scan.rows_col5, scan.rows_col6, scan.rows_col7};
        nrows = clamp_size(cfg_rows);
        ncols = clamp_size(cfg_cols);
        first = due_events.size();
        // Capture: each in-range set bit reloads the flag and may mark the key.
        for (int unsigned c = 0; c < ncols; c++) begin
            for (int unsigned r = 0; r < nrows; r++) begin
                if (cols[c][r]) begin
                    still_down = scan.raw_key_status;
                    if (still_down) begin
                        key_track[(r << HALF_W) + c].prs = 1'b1;
                    end
                end
            end
        end
        // Row-major sweep over the configured keys.
        for (int unsigned r = 0; r < nrows; r++) begin
            for (int unsigned c = 0; c < ncols; c++) begin
                idx              = (r << HALF_W) + c;
                ev.has_event     = 1'b1;
                ev.scan_code     = idx[CODE_W-1:0];
                ev.still_pressed = still_down;
                ev.last          = 1'b0;
                case ({key_track[idx].prs, key_track[idx].rep})
                    2'b01: begin
                        ev.key_down = 1'b0;
                        due_events.push_back(ev);
                        key_track[idx] = '0;
                    end
                    2'b10: begin
                        ev.key_down = 1'b1;
                        due_events.push_back(ev);
                        key_track[idx] = '{prs: 1'b0, rep: 1'b1};
                    end
                    2'b11: begin
                        key_track[idx] = '{prs: 1'b0, rep: 1'b1};
                    end
                    default: begin
                    end
                endcase
            end
        end
        // A scan without events still reports completion.
        if (due_events.size() == first) begin
            ev               = '0;
            ev.still_pressed = still_down;
            ev.last          = 1'b1;
            due_events.push_back(ev);
        end else begin
            due_events[due_events.size() - 1].last = 1'b1;
        end
    endtask

    // Sends one scan request, sometimes after a random gap when idling is on.
    task automatic send_scan(t_in_item scan);
        if (in_idling && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= scan;
        do @(posedge i_clk); while (o_in_stall);
        predict_scan(scan);
    endtask

    // Stops sending and waits until every predicted event has been seen.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (due_events.size() != 0) @(posedge i_clk);
        repeat (SWEEP_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_xfer(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes both size registers and reads them back. Call only when idle.
    task automatic set_sizes(logic [SIZE_W-1:0] rows, logic [SIZE_W-1:0] cols);
        logic [31:0] rd;
        apb_xfer(1'b1, ADDR_NUM_ROWS, 32'(rows), rd);
        cfg_rows = rows;
        apb_xfer(1'b1, ADDR_NUM_COLS, 32'(cols), rd);
        cfg_cols = cols;
        apb_xfer(1'b0, ADDR_NUM_ROWS, '0, rd);
        if (rd !== 32'(rows)) begin
            mismatches++;
            $error("num_rows: expected %0d, got %0d", rows, rd);
        end
        apb_xfer(1'b0, ADDR_NUM_COLS, '0, rd);
        if (rd !== 32'(cols)) begin
            mismatches++;
            $error("num_cols: expected %0d, got %0d", cols, rd);
        end
    endtask

    // Mostly keys going down and up over successive scans, with some noise.
    task automatic send_random_scan();
        int unsigned pick;
        int unsigned nrows;
        int unsigned ncols;
        int unsigned rr;
        int unsigned cc;
        nrows = clamp_size(cfg_rows);
        ncols = clamp_size(cfg_cols);
        pick  = $urandom_range(0, 99);
        if ($urandom_range(0, 39) == 0) begin
            drain_results();
        end
        if (pick < 15) begin
            send_scan(scan_from_map({$urandom, $urandom}, 1'($urandom_range(0, 1))));
        end else if (pick < 22) begin
            // Status already low while bits are still seen.
            send_scan(scan_from_map(held_keys, 1'b0));
        end else if (pick < 28) begin
            held_keys = '0;
            send_scan(scan_from_map(held_keys, 1'($urandom_range(0, 1))));
        end else begin
            repeat ($urandom_range(0, 3)) begin
                if (nrows != 0 && ncols != 0 && $urandom_range(0, 3) != 0) begin
                    rr = $urandom_range(0, nrows - 1);
                    cc = $urandom_range(0, ncols - 1);
                end else begin
                    rr = $urandom_range(0, 7);
                    cc = $urandom_range(0, 7);
                end
                held_keys[(rr << HALF_W) + cc] = ~held_keys[(rr << HALF_W) + cc];
            end
            send_scan(scan_from_map(held_keys, 1'b1));
        end
    endtask

    // Scans with nothing set, with the status bit low and high.
    task automatic test_idle_scans();
        send_scan(scan_from_map(64'd0, 1'b0));
        send_scan(scan_from_map(64'd0, 1'b1));
    endtask

    // Every key pressed, held, then all released with the flag left stale.
    task automatic test_full_matrix();
        send_scan(scan_from_map('1, 1'b1));
        send_scan(scan_from_map('1, 1'b1));
        send_scan(scan_from_map(64'd0, 1'b0));
    endtask

    // Corner keys against the raw status bit.
    task automatic test_status_bit();
        send_scan(scan_from_map(64'h8000_0000_0000_0000, 1'b0));
        send_scan(scan_from_map(64'h8000_0000_0000_0001, 1'b1));
        send_scan(scan_from_map(64'h8000_0000_0000_0001, 1'b0));
    endtask

    // Zero size, sizes above the matrix, the smallest size and keys left outside it.
    task automatic test_size_limits();
        drain_results();
        set_sizes(4'd0, 4'd8);
        send_scan(scan_from_map('1, 1'b1));
        drain_results();
        set_sizes(4'd15, 4'd9);
        send_scan(scan_from_map('1, 1'b1));
        drain_results();
        set_sizes(4'd1, 4'd1);
        send_scan(scan_from_map(~64'd1, 1'b0));
        send_scan(scan_from_map(64'd0, 1'b1));
        drain_results();
        set_sizes(4'd8, 4'd8);
        send_scan(scan_from_map(64'd0, 1'b1));
    endtask

    // Random scans over a range of keypad sizes, idling switched per phase.
    task automatic test_random_sizes();
        logic [SIZE_W-1:0] ph_rows [8];
        logic [SIZE_W-1:0] ph_cols [8];
        ph_rows = '{4'd8, 4'd3, 4'd1, 4'd0, 4'd15, 4'd8, 4'd1, 4'($urandom_range(0, 15))};
        ph_cols = '{4'd8, 4'd5, 4'd1, 4'd6, 4'd9, 4'd1, 4'd8, 4'($urandom_range(0, 15))};
        held_keys = '0;
        for (int ph = 0; ph < 8; ph++) begin
            drain_results();
            set_sizes(ph_rows[ph], ph_cols[ph]);
            in_idling  = ($urandom_range(0, 3) != 0);
            out_idling = ($urandom_range(0, 3) != 0);
            repeat (38) send_random_scan();
        end
    endtask

    // Full matrix with no idling on either side.
    task automatic test_steady_stream();
        drain_results();
        set_sizes(4'd8, 4'd8);
        in_idling  = 1'b0;
        out_idling = 1'b0;
        repeat (45) send_random_scan();
    endtask

    initial begin
        for (int k = 0; k < DIM * DIM; k++) begin
            key_track[k] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_scans();
        test_full_matrix();
        test_status_bit();
        test_size_limits();
        test_random_sizes();
        test_steady_stream();
        drain_results();
        if (mismatches == 0) begin
            $display("PASS keypad_matrix_event_tracker_top");
        end else begin
            $display("FAIL keypad_matrix_event_tracker_top");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/kmet_pkg.sv
hdl/kmet_cell.sv
hdl/kmet_sweep.sv
hdl/keypad_matrix_event_tracker_top.sv
dv/tb_top.sv
